// File: rtl/core/bm25sa_pkg.sv
// Shared types, codes and constants of the BM25 score accumulator.
package bm25sa_pkg;

	// Command codes of an input word
	localparam logic [1:0] CMD_ACC = 2'd0;
	localparam logic [1:0] CMD_CLR = 2'd1;
	localparam logic [1:0] CMD_RD  = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_K1  = 2'd0;
	localparam logic [1:0] CFG_B   = 2'd1;
	localparam logic [1:0] CFG_AVG = 2'd2;

	// Register reset values
	localparam logic [15:0] K1_RST  = 16'd4915;
	localparam logic [15:0] B_RST   = 16'd49152;
	localparam logic [23:0] AVG_RST = 24'd100;

	// Default score memory depth
	localparam int DOC_SLOTS_DEF = 65536;

	// Shared divider widths
	localparam int DIV_NW = 64;
	localparam int DIV_DW = 58;

	// Divider operand selection
	typedef enum logic {
		DSEL_LEN,
		DSEL_TF
	} dsel_t;

	// Controller to datapath commands
	typedef struct packed {
		logic  latch;
		logic  div_start;
		dsel_t div_sel;
		logic  mod_load;
		logic  slot_load;
		logic  mul1;
		logic  mul2;
		logic  den_load;
		logic  r_load;
		logic  mul3;
		logic  mem_rd;
		logic  finish;
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic       div_done;
		logic [1:0] cmd;
		logic       tf_zero;
		logic       out_free;
	} dp_stat_t;

endpackage

// File: rtl/core/bm25sa_div.sv
// Shared restoring divider, one quotient bit per cycle.
module bm25sa_div
	import bm25sa_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quot
);

	localparam int CW = $clog2(DIV_NW);
	localparam logic [CW-1:0] LAST = CW'(DIV_NW - 1);

	logic [DIV_NW-1:0] n_q;
	logic [DIV_DW-1:0] r_q;
	logic [DIV_DW-1:0] d_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [DIV_DW:0]   trial;
	logic [DIV_DW:0]   diff;
	logic              ge;

	// trial subtract of the shifted remainder
	assign trial = {r_q, n_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = trial >= {1'b0, d_q};

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == LAST) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// operands: quotient bits shift in behind the dividend
	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= num;
			r_q <= '0;
			d_q <= den;
		end else if (busy_q) begin
			n_q <= {n_q[DIV_NW-2:0], ge};
			r_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
		end
	end

	assign done = done_q;
	assign quot = n_q;

endmodule

// File: rtl/core/bm25sa_ctrl.sv
// Sequencing state machine of the BM25 score accumulator.
module bm25sa_ctrl
	import bm25sa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  dp_stat_t   stat,
	output ctrl_cmd_t  cmd
);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_MOD   = 12'b000000000010,
		S_MODW  = 12'b000000000100,
		S_MUL1  = 12'b000000001000,
		S_MUL2  = 12'b000000010000,
		S_DIV1  = 12'b000000100000,
		S_DIV1W = 12'b000001000000,
		S_DIV2  = 12'b000010000000,
		S_DIV2W = 12'b000100000000,
		S_MUL3  = 12'b001000000000,
		S_RD    = 12'b010000000000,
		S_FIN   = 12'b100000000000
	} state_t;

	state_t state_q, state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid) state_d = S_MOD;
			end
			S_MOD: begin
				cmd.mod_load = 1'b1;
				state_d      = S_MODW;
			end
			S_MODW: begin
				cmd.slot_load = 1'b1;
				if (stat.cmd == CMD_ACC && !stat.tf_zero) state_d = S_MUL1;
				else state_d = S_RD;
			end
			S_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d  = S_MUL2;
			end
			S_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d  = S_DIV1;
			end
			S_DIV1: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_LEN;
				state_d       = S_DIV1W;
			end
			S_DIV1W: begin
				if (stat.div_done) begin
					cmd.den_load = 1'b1;
					state_d      = S_DIV2;
				end
			end
			S_DIV2: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = DSEL_TF;
				state_d       = S_DIV2W;
			end
			S_DIV2W: begin
				if (stat.div_done) begin
					cmd.r_load = 1'b1;
					state_d    = S_MUL3;
				end
			end
			S_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d  = S_RD;
			end
			S_RD: begin
				cmd.mem_rd = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// File: rtl/core/bm25sa_dp.sv
// Datapath: config registers, term arithmetic, score memory and result word.
module bm25sa_dp
	import bm25sa_pkg::*;
#(
	parameter int DOC_SLOTS = DOC_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  ctrl_cmd_t   ctl,
	output dp_stat_t    stat,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic [1:0]  cmd,
	input  logic [23:0] query_weight,
	input  logic [15:0] term_freq,
	input  logic [15:0] doc_id,
	input  logic [23:0] doc_length,
	input  logic        last_in_list,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] score_value,
	output logic [31:0] list_max,
	output logic        list_done,
	output logic        saturated
);

	localparam int AW = (DOC_SLOTS > 1) ? $clog2(DOC_SLOTS) : 1;
	// slot reduction by reciprocal multiply, exact for any 16-bit id
	localparam int MOD_L = $clog2(DOC_SLOTS);
	localparam int MOD_S = 16 + MOD_L;
	localparam logic [16:0] MOD_M = 17'((64'd1 << MOD_S) / 64'(DOC_SLOTS) + 64'd1);
	localparam logic [16:0] SLOTS_C = 17'(DOC_SLOTS);

	// configuration
	logic [15:0] k1_q;
	logic [15:0] b_q;
	logic [23:0] avg_q;
	logic [23:0] avg_eff;

	// latched word
	logic [1:0]  cmd_q;
	logic [23:0] qw_q;
	logic [15:0] tf_q;
	logic [15:0] id_q;
	logic [23:0] len_q;
	logic        last_q;

	// arithmetic
	logic [32:0]   mod_prod;
	logic [15:0]   modq_q;
	logic [32:0]   mod_back;
	logic [32:0]   mod_rem;
	logic [AW-1:0] slot_q;
	logic [31:0]   kb_q;
	logic [32:0]   kinv_q;
	logic [40:0]   qk_q;
	logic [55:0]   kbl_q;
	logic [57:0]   den_q;
	logic [20:0]   r_q;
	logic [31:0]   term_q;
	logic [61:0]   prod;

	// divider
	logic [DIV_NW-1:0] div_num;
	logic [DIV_DW-1:0] div_den;
	logic              div_done;
	logic [DIV_NW-1:0] div_quot;

	// memory and result
	logic [31:0] mem [DOC_SLOTS];
	logic [31:0] rd_q;
	logic [31:0] rmax_q;
	logic        oval_q;
	logic [31:0] score_q;
	logic [31:0] lmax_q;
	logic        done_q;
	logic        sat_q;
	logic [32:0] sum;
	logic [31:0] acc_val;
	logic        acc_sat;
	logic [31:0] acc_max;

	// config write port
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q  <= K1_RST;
			b_q   <= B_RST;
			avg_q <= AVG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_K1:  k1_q  <= cfg_data[15:0];
				CFG_B:   b_q   <= cfg_data[15:0];
				CFG_AVG: avg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign avg_eff = (avg_q == '0) ? 24'd1 : avg_q;

	// divider operand select
	always_comb begin
		case (ctl.div_sel)
			DSEL_TF: begin
				div_num = {tf_q, 48'b0};
				div_den = den_q;
			end
			default: begin
				div_num = {8'b0, kbl_q};
				div_den = {34'b0, avg_eff};
			end
		endcase
	end

	bm25sa_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot)
	);

	// slot = id mod DOC_SLOTS over two steps
	assign mod_prod = 33'(id_q) * 33'(MOD_M);
	assign mod_back = 33'(modq_q) * 33'(SLOTS_C);
	assign mod_rem  = {17'b0, id_q} - mod_back;

	assign prod = 62'(qk_q) * 62'(r_q);

	// input latch and arithmetic steps
	always_ff @(posedge clk) begin
		if (ctl.latch) begin
			cmd_q  <= cmd;
			qw_q   <= query_weight;
			tf_q   <= term_freq;
			id_q   <= doc_id;
			len_q  <= doc_length;
			last_q <= last_in_list;
			term_q <= '0;
		end
		if (ctl.mod_load) modq_q <= 16'(mod_prod >> MOD_S);
		if (ctl.slot_load) slot_q <= mod_rem[AW-1:0];
		if (ctl.mul1) begin
			kb_q   <= 32'(k1_q) * 32'(b_q);
			kinv_q <= 33'(k1_q) * 33'(17'd65536 - {1'b0, b_q});
			qk_q   <= 41'(qw_q) * 41'({1'b0, k1_q} + 17'd4096);
		end
		if (ctl.mul2) kbl_q <= 56'(kb_q) * 56'(len_q);
		if (ctl.den_load)
			den_q <= {14'b0, tf_q, 28'b0} + {25'b0, kinv_q} + {2'b0, div_quot[55:0]};
		if (ctl.r_load) r_q <= div_quot[20:0];
		if (ctl.mul3) term_q <= {2'b0, prod[61:32]};
	end

	// score memory, registered read
	always_ff @(posedge clk) begin
		if (ctl.mem_rd) rd_q <= mem[slot_q];
		if (ctl.finish && cmd_q == CMD_ACC) mem[slot_q] <= acc_val;
		if (ctl.finish && cmd_q == CMD_CLR) mem[slot_q] <= '0;
	end

	// saturating add and list maximum
	assign sum     = {1'b0, rd_q} + {1'b0, term_q};
	assign acc_sat = sum[32];
	assign acc_val = acc_sat ? 32'hFFFF_FFFF : sum[31:0];
	assign acc_max = (acc_val > rmax_q) ? acc_val : rmax_q;

	// result word and running maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oval_q <= 1'b0;
			rmax_q <= '0;
		end else begin
			if (ctl.finish) oval_q <= 1'b1;
			else if (out_ready) oval_q <= 1'b0;
			if (ctl.finish && cmd_q == CMD_ACC) rmax_q <= last_q ? '0 : acc_max;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			case (cmd_q)
				CMD_ACC: begin
					score_q <= acc_val;
					lmax_q  <= acc_max;
					done_q  <= last_q;
					sat_q   <= acc_sat;
				end
				CMD_RD: begin
					score_q <= rd_q;
					lmax_q  <= rmax_q;
					done_q  <= 1'b0;
					sat_q   <= 1'b0;
				end
				default: begin
					score_q <= '0;
					lmax_q  <= rmax_q;
					done_q  <= 1'b0;
					sat_q   <= 1'b0;
				end
			endcase
		end
	end

	assign stat.div_done = div_done;
	assign stat.cmd      = cmd_q;
	assign stat.tf_zero  = (tf_q == '0);
	assign stat.out_free = !oval_q || out_ready;

	assign out_valid   = oval_q;
	assign score_value = score_q;
	assign list_max    = lmax_q;
	assign list_done   = done_q;
	assign saturated   = sat_q;

endmodule

// File: rtl/core/bm25_score_accumulate.sv
// Top level of the BM25 score accumulator; one word at a time, next taken as the result appears.
// Accumulate with nonzero term frequency: slot reduction, multiplies, two 64-step divisions,
// a final multiply, memory read and write-back; the divisions set the pace.
// Clear, read, zero frequency and unused command: slot reduction, memory read and finish only.
// A stalled result holds the final step until the output frees up.
// Reset clears control, the running maximum and config registers; score memory is not cleared.
module bm25_score_accumulate
	import bm25sa_pkg::*;
#(
	parameter int DOC_SLOTS = DOC_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [23:0] query_weight,
	input  logic [15:0] term_freq,
	input  logic [15:0] doc_id,
	input  logic [23:0] doc_length,
	input  logic        last_in_list,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] score_value,
	output logic [31:0] list_max,
	output logic        list_done,
	output logic        saturated,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	ctrl_cmd_t ctl;
	dp_stat_t  stat;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	bm25sa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (ctl)
	);

	bm25sa_dp #(
		.DOC_SLOTS (DOC_SLOTS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.stat         (stat),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.query_weight (query_weight),
		.term_freq    (term_freq),
		.doc_id       (doc_id),
		.doc_length   (doc_length),
		.last_in_list (last_in_list),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.score_value  (score_value),
		.list_max     (list_max),
		.list_done    (list_done),
		.saturated    (saturated)
	);

endmodule

// File: sim/tb_top.sv
// Self-checking testbench for the BM25 score accumulator: random postings, checked result words.
`timescale 1ns / 100ps

module tb_top;
	import bm25sa_pkg::*;

	// Unused command code; the package names only the three real ones
	localparam logic [1:0] CMD_NOP = 2'd3;
	localparam int CYCLE_LIMIT = 3000000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		logic [1:0]  cmd;
		logic [23:0] qv;
		logic [15:0] tf;
		logic [15:0] slot;
		logic [23:0] len;
		logic        last;
	} posting_t;

	typedef struct {
		logic [31:0] score;
		logic [31:0] maxv;
		logic        done;
		logic        sat;
	} score_word_t;

	typedef struct {
		logic [1:0]  idx;
		logic [23:0] data;
	} reg_write_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd = CMD_ACC;
	logic [23:0] query_weight = '0;
	logic [15:0] term_freq = '0;
	logic [15:0] doc_id = '0;
	logic [23:0] doc_length = '0;
	logic        last_in_list = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] score_value;
	logic [31:0] list_max;
	logic        list_done;
	logic        saturated;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = CFG_K1;
	logic [23:0] cfg_data = '0;

	bm25_score_accumulate DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Shadow state of the block
	logic [31:0] shadow_scores [logic [15:0]];
	logic [31:0] shadow_max = '0;
	logic [15:0] shadow_k1 = K1_RST;
	logic [15:0] shadow_b = B_RST;
	logic [23:0] shadow_avg = AVG_RST;

	posting_t    posting_queue[$];
	score_word_t expected_scores[$];
	reg_write_t  reg_queue[$];
	logic [15:0] slot_pool[$];
	int          errors = 0;
	int          cycles = 0;

	// Score update for one accepted posting
	function automatic score_word_t score_posting(posting_t p);
		bit [63:0] k, b, a, den, r, term, sum, qv, tf, len;
		score_word_t res;
		res.score = '0;
		res.maxv = shadow_max;
		res.done = 1'b0;
		res.sat = 1'b0;
		qv = 64'(p.qv);
		tf = 64'(p.tf);
		len = 64'(p.len);
		case (p.cmd)
			CMD_ACC: begin
				term = '0;
				if (tf != 0) begin
					k = 64'(shadow_k1);
					b = 64'(shadow_b);
					a = (shadow_avg == 0) ? 64'd1 : 64'(shadow_avg);
					den = (tf << 28) + k * (64'd65536 - b) + (k * b * len) / a;
					r = (tf << 48) / den;
					term = (qv * (k + 64'd4096) * r) >> 32;
				end
				sum = 64'(shadow_scores.exists(p.slot) ? shadow_scores[p.slot] : 32'd0) + term;
				if (sum > 64'hFFFF_FFFF) begin
					sum = 64'hFFFF_FFFF;
					res.sat = 1'b1;
				end
				res.score = sum[31:0];
				shadow_scores[p.slot] = sum[31:0];
				if (sum[31:0] > shadow_max)
					shadow_max = sum[31:0];
				res.maxv = shadow_max;
				res.done = p.last;
				if (p.last)
					shadow_max = '0;
			end
			CMD_CLR: shadow_scores[p.slot] = '0;
			CMD_RD: res.score = shadow_scores.exists(p.slot) ? shadow_scores[p.slot] : 32'd0;
			default: ;
		endcase
		return res;
	endfunction

	// Posting driver: bursts with random gaps
	int burst_left = 1;
	int gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		posting_t p;
		posting_t cur;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) begin
				cur.cmd = cmd;
				cur.qv = query_weight;
				cur.tf = term_freq;
				cur.slot = doc_id;
				cur.len = doc_length;
				cur.last = last_in_list;
				expected_scores.push_back(score_posting(cur));
			end
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (posting_queue.size() > 0) begin
				p = posting_queue.pop_front();
				cmd <= p.cmd;
				query_weight <= p.qv;
				term_freq <= p.tf;
				doc_id <= p.slot;
				doc_length <= p.len;
				last_in_list <= p.last;
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 12);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Register write driver
	always @(posedge clk or negedge arst_n) begin
		reg_write_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else if (!cfg_valid || cfg_ready) begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_K1: shadow_k1 = cfg_data[15:0];
					CFG_B: shadow_b = cfg_data[15:0];
					CFG_AVG: shadow_avg = cfg_data;
					default: ;
				endcase
			end
			if (reg_queue.size() > 0) begin
				w = reg_queue.pop_front();
				cfg_index <= w.idx;
				cfg_data <= w.data;
				cfg_valid <= 1'b1;
			end else begin
				cfg_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern: always ready, random stalls or a periodic stall pattern
	int stall_mode = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (cycles % 400 == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				default: out_ready <= ((cycles / 7) % 3 != 0);
			endcase
		end
	end

	// Result monitor
	always @(posedge clk) begin
		score_word_t e;
		if (arst_n && out_valid && out_ready) begin
			if (expected_scores.size() == 0) begin
				$display("%0t: unexpected result word score=%h max=%h", $time,
					score_value, list_max);
				errors++;
			end else begin
				e = expected_scores.pop_front();
				if (score_value !== e.score) begin
					$display("%0t: score_value exp %h got %h", $time, e.score, score_value);
					errors++;
				end
				if (list_max !== e.maxv) begin
					$display("%0t: list_max exp %h got %h", $time, e.maxv, list_max);
					errors++;
				end
				if (list_done !== e.done) begin
					$display("%0t: list_done exp %b got %b", $time, e.done, list_done);
					errors++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated exp %b got %b", $time, e.sat, saturated);
					errors++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic posting_t mk(logic [1:0] c, logic [23:0] q, logic [15:0] t,
			logic [15:0] s, logic [23:0] l, logic e);
		posting_t p;
		p.cmd = c;
		p.qv = q;
		p.tf = t;
		p.slot = s;
		p.len = l;
		p.last = e;
		return p;
	endfunction

	function automatic logic [15:0] pool_slot();
		return slot_pool[$urandom_range(0, slot_pool.size() - 1)];
	endfunction

	// One random posting; mostly accumulates on written slots
	function automatic posting_t rand_posting();
		int sel;
		logic [23:0] q;
		logic [15:0] t;
		logic [23:0] l;
		sel = $urandom_range(0, 99);
		case ($urandom_range(0, 3))
			0: q = 24'hFFFFFF;
			1: q = 24'($urandom_range(0, 255));
			default: q = 24'($urandom);
		endcase
		case ($urandom_range(0, 7))
			0: t = '0;
			1, 2: t = 16'($urandom_range(1, 20));
			default: t = 16'($urandom);
		endcase
		l = ($urandom_range(0, 1) == 0) ? 24'($urandom_range(0, 400)) : 24'($urandom);
		if (sel < 85)
			return mk(CMD_ACC, q, t, pool_slot(), l, $urandom_range(0, 7) == 0);
		else if (sel < 90)
			return mk(CMD_RD, 24'($urandom), 16'($urandom), pool_slot(), 24'($urandom),
				1'($urandom));
		else if (sel < 94)
			return mk(CMD_CLR, 24'($urandom), 16'($urandom), pool_slot(), 24'($urandom),
				1'($urandom));
		else if (sel < 97)
			return mk(CMD_CLR, 24'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
				1'($urandom));
		return mk(CMD_NOP, 24'($urandom), 16'($urandom), 16'($urandom), 24'($urandom),
			1'($urandom));
	endfunction

	task automatic wait_idle();
		while (posting_queue.size() > 0 || in_valid || expected_scores.size() > 0 ||
				reg_queue.size() > 0 || cfg_valid)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_regs(logic [15:0] k, logic [15:0] b, logic [23:0] a);
		reg_write_t w;
		w.idx = CFG_K1; w.data = 24'(k); reg_queue.push_back(w);
		w.idx = CFG_B; w.data = 24'(b); reg_queue.push_back(w);
		w.idx = CFG_AVG; w.data = a; reg_queue.push_back(w);
		wait_idle();
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Slot pool; every slot is cleared before it is accumulated or read
		slot_pool = '{16'h0000, 16'hFFFF, 16'hAAAA, 16'h5555};
		repeat (4) slot_pool.push_back(16'($urandom));
		foreach (slot_pool[i])
			posting_queue.push_back(mk(CMD_CLR, '0, '0, slot_pool[i], '0, 1'b0));

		// Directed: field extremes, zero frequency, read, unused command, list end, clear
		posting_queue.push_back(mk(CMD_ACC, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0));
		posting_queue.push_back(mk(CMD_ACC, 24'hFFFFFF, 16'd1, 16'h0000, 24'd0, 1'b0));
		posting_queue.push_back(mk(CMD_ACC, 24'hFFFFFF, 16'd0, 16'hAAAA, 24'd50, 1'b0));
		posting_queue.push_back(mk(CMD_ACC, 24'd0, 16'd3, 16'h5555, 24'd100, 1'b1));
		posting_queue.push_back(mk(CMD_RD, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1));
		posting_queue.push_back(mk(CMD_NOP, 24'hFFFFFF, 16'hFFFF, 16'h1234, 24'hFFFFFF, 1'b1));
		posting_queue.push_back(mk(CMD_ACC, 24'h123456, 16'd7, 16'h0000, 24'd200, 1'b1));
		posting_queue.push_back(mk(CMD_CLR, '0, '0, 16'h0000, '0, 1'b1));
		posting_queue.push_back(mk(CMD_RD, '0, '0, 16'h0000, '0, 1'b0));
		wait_idle();

		// Large k1 and zero average length: large repeated terms on a hot slot
		set_regs(16'hFFFF, 16'hFFFF, 24'd0);
		repeat (12)
			posting_queue.push_back(mk(CMD_ACC, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'd1, 1'b0));
		posting_queue.push_back(mk(CMD_ACC, 24'hFFFFFF, 16'hFFFF, 16'hFFFF, 24'd1, 1'b1));
		wait_idle();

		// Random phases over several register settings
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: set_regs(K1_RST, B_RST, AVG_RST);
				1: set_regs(16'h0000, 16'h0000, 24'd1);
				2: set_regs(16'hFFFF, 16'hFFFF, 24'hFFFFFF);
				3: set_regs(16'($urandom), 16'($urandom), 24'($urandom_range(1, 1000)));
				default: set_regs(16'($urandom), 16'($urandom), 24'($urandom));
			endcase
			repeat (240) posting_queue.push_back(rand_posting());
			wait_idle();
		end

		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
